[hw/rtl/clle_pkg.sv]
// Package for the cursor linked-list engine: sizes, codes and sequencer states.
package clle_pkg;

  localparam int NODES = 128;
  localparam int IW    = $clog2(NODES);
  localparam int SW    = $clog2(NODES + 1);

  typedef logic [IW-1:0] idx_t;
  typedef logic [SW-1:0] step_t;

  typedef enum logic [2:0] {
    ACT_INSERT      = 3'd0,
    ACT_DELETE      = 3'd1,
    ACT_FIND        = 3'd2,
    ACT_MAKE_EMPTY  = 3'd3,
    ACT_DELETE_LIST = 3'd4,
    ACT_ADVANCE     = 3'd5,
    ACT_RETRIEVE    = 3'd6,
    ACT_IS_EMPTY    = 3'd7
  } action_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_FREE   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_A,
    S_INS_B,
    S_INS_C,
    S_INS_D,
    S_INS_E,
    S_SRCH_LINK,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_TAIL_START,
    S_TAIL_CHK,
    S_TAIL_FIX,
    S_TAIL_FIX2,
    S_DEL_B,
    S_ADV,
    S_RET,
    S_ISE,
    S_OUT
  } state_t;

endpackage

[hw/rtl/clle_link_store.sv]
// Link store: link memory with per-entry valid bits that overlay the reset chain.
module clle_link_store import clle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic we,
  input  idx_t waddr,
  input  idx_t wdata,
  input  idx_t raddr,
  output idx_t rdata
);

  idx_t             mem [NODES];
  logic [NODES-1:0] vld;
  idx_t             rd_mem;
  idx_t             rd_addr;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_mem  <= mem[raddr];
    rd_addr <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[raddr];
      if (we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  // unwritten entry i reads i+1, the last one reads 0
  always_comb begin
    if (rd_vld) begin
      rdata = rd_mem;
    end else if (rd_addr == IW'(NODES - 1)) begin
      rdata = '0;
    end else begin
      rdata = rd_addr + 1'b1;
    end
  end

endmodule

[hw/rtl/cursor_linked_list_engine_top.sv]
// Top level of the cursor linked-list engine: sequencer, value store, output register.
//
//  channel | handshake            | fields
//  --------+----------------------+-----------------------------------
//  input   | in_valid / in_ready  | action, header, pos, value
//  output  | out_valid / out_ready| out_pos, out_value, flag, status
//
// One item at a time; in_ready is high only in the idle state.
// Each state does at most one link-memory access; a search steps through S_SRCH_CHK
// and S_SRCH_CMP for each link, a tail walk through S_TAIL_CHK alone.
// Reset is synchronous; the link chain needs no clearing pass (valid bits).
// A waiting result sits in the output register; the next item is taken meanwhile.
module cursor_linked_list_engine_top import clle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [6:0]  header,
  input  logic [6:0]  pos,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_pos,
  output logic [31:0] out_value,
  output logic        flag,
  output logic [1:0]  status
);

  state_t  state, state_next;

  // item registers
  action_t act;
  idx_t    hdr, ps;
  logic [31:0] x;

  // walk registers
  idx_t  cur, cur_next;
  idx_t  last, last_next;
  idx_t  node, node_next;
  idx_t  tl, tl_next;
  step_t steps, steps_next;

  // result registers
  idx_t        res_pos, res_pos_next;
  logic [31:0] res_val, res_val_next;
  logic        res_flag, res_flag_next;
  logic [1:0]  res_st, res_st_next;

  // link store port
  logic l_we;
  idx_t l_waddr, l_wdata, l_raddr, l_rdata;

  // value store
  logic [31:0] vmem [NODES];
  logic [31:0] v_rdata;
  logic        v_we;
  idx_t        v_raddr;

  clle_link_store u_links (
    .clk   (clk),
    .rst   (rst),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign v_raddr = (state == S_DISPATCH) ? ps : cur;

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[node] <= x;
    end
    v_rdata <= vmem[v_raddr];
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act <= action_t'(action);
      hdr <= header[IW-1:0];
      ps  <= pos[IW-1:0];
      x   <= value;
    end
    cur      <= cur_next;
    last     <= last_next;
    node     <= node_next;
    tl       <= tl_next;
    steps    <= steps_next;
    res_pos  <= res_pos_next;
    res_val  <= res_val_next;
    res_flag <= res_flag_next;
    res_st   <= res_st_next;
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_pos   <= 7'(res_pos);
      out_value <= res_val;
      flag      <= res_flag;
      status    <= res_st;
    end
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    last_next     = last;
    node_next     = node;
    tl_next       = tl;
    steps_next    = steps;
    res_pos_next  = res_pos;
    res_val_next  = res_val;
    res_flag_next = res_flag;
    res_st_next   = res_st;
    l_we          = 1'b0;
    l_waddr       = '0;
    l_wdata       = '0;
    l_raddr       = cur;
    v_we          = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_pos_next  = '0;
        res_val_next  = '0;
        res_flag_next = 1'b0;
        res_st_next   = ST_OK;
        steps_next    = '0;
        case (act)
          ACT_INSERT: begin
            l_raddr    = '0;
            state_next = S_INS_A;
          end
          ACT_DELETE, ACT_FIND: begin
            l_raddr    = hdr;
            last_next  = hdr;
            state_next = S_SRCH_LINK;
          end
          ACT_MAKE_EMPTY: begin
            cur_next   = '0;
            state_next = S_TAIL_START;
          end
          ACT_DELETE_LIST: begin
            cur_next   = hdr;
            state_next = S_TAIL_START;
          end
          ACT_ADVANCE: begin
            l_raddr    = ps;
            state_next = S_ADV;
          end
          ACT_RETRIEVE: begin
            state_next = S_RET;
          end
          default: begin
            l_raddr    = hdr;
            state_next = S_ISE;
          end
        endcase
      end

      // insert: free head -> node, then relink around pos
      S_INS_A: begin
        node_next = l_rdata;
        if (l_rdata == '0) begin
          res_st_next = ST_NO_FREE;
          state_next  = S_OUT;
        end else begin
          l_raddr    = l_rdata;
          state_next = S_INS_B;
        end
      end
      S_INS_B: begin
        l_we       = 1'b1;
        l_waddr    = '0;
        l_wdata    = l_rdata;
        state_next = S_INS_C;
      end
      S_INS_C: begin
        l_raddr    = ps;
        state_next = S_INS_D;
      end
      S_INS_D: begin
        l_we       = 1'b1;
        l_waddr    = node;
        l_wdata    = l_rdata;
        state_next = S_INS_E;
      end
      S_INS_E: begin
        l_we         = 1'b1;
        l_waddr      = ps;
        l_wdata      = node;
        v_we         = 1'b1;
        res_pos_next = node;
        state_next   = S_OUT;
      end

      // search: S_SRCH_CHK then S_SRCH_CMP for each link
      S_SRCH_LINK: begin
        cur_next   = l_rdata;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (cur == '0 || steps == SW'(NODES)) begin
          res_st_next = ST_NOT_FOUND;
          state_next  = S_OUT;
        end else begin
          l_raddr    = cur;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (v_rdata == x) begin
          node_next    = cur;
          res_pos_next = cur;
          if (act == ACT_DELETE) begin
            l_we       = 1'b1;
            l_waddr    = last;
            l_wdata    = l_rdata;
            cur_next   = '0;
            steps_next = '0;
            state_next = S_TAIL_START;
          end else begin
            state_next = S_OUT;
          end
        end else begin
          last_next  = cur;
          cur_next   = l_rdata;
          steps_next = steps + 1'b1;
          state_next = S_SRCH_CHK;
        end
      end

      // tail walk from cur, bounded by NODES links
      S_TAIL_START: begin
        l_raddr    = cur;
        state_next = S_TAIL_CHK;
      end
      S_TAIL_CHK: begin
        if (l_rdata != '0 && steps != SW'(NODES)) begin
          cur_next   = l_rdata;
          steps_next = steps + 1'b1;
          l_raddr    = l_rdata;
        end else begin
          tl_next    = cur;
          l_raddr    = (act == ACT_MAKE_EMPTY) ? hdr : '0;
          state_next = S_TAIL_FIX;
        end
      end
      S_TAIL_FIX: begin
        l_we    = 1'b1;
        l_waddr = tl;
        if (act == ACT_DELETE) begin
          l_wdata    = node;
          state_next = S_DEL_B;
        end else begin
          l_wdata    = l_rdata;
          state_next = S_TAIL_FIX2;
        end
      end
      S_TAIL_FIX2: begin
        l_we       = 1'b1;
        l_waddr    = (act == ACT_MAKE_EMPTY) ? hdr : '0;
        l_wdata    = (act == ACT_MAKE_EMPTY) ? '0 : hdr;
        state_next = S_OUT;
      end
      S_DEL_B: begin
        l_we       = 1'b1;
        l_waddr    = node;
        l_wdata    = '0;
        state_next = S_OUT;
      end

      S_ADV: begin
        res_pos_next  = l_rdata;
        res_flag_next = (l_rdata == '0);
        state_next    = S_OUT;
      end
      S_RET: begin
        res_val_next = v_rdata;
        state_next   = S_OUT;
      end
      S_ISE: begin
        res_flag_next = (l_rdata == '0);
        state_next    = S_OUT;
      end

      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the cursor linked-list engine: directed table plus random actions.
`timescale 1ns / 1ps

module tb_top;
  import clle_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = '0;
  logic [6:0]  header = '0;
  logic [6:0]  pos = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_pos;
  logic [31:0] out_value;
  logic        flag;
  logic [1:0]  status;

  always #5 clk = ~clk;

  cursor_linked_list_engine_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .header(header), .pos(pos), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos(out_pos), .out_value(out_value), .flag(flag), .status(status)
  );

  typedef struct packed {
    logic [6:0]  opos;
    logic [31:0] oval;
    logic        oflag;
    logic [1:0]  ostat;
  } answer_t;

  typedef struct {
    action_t     act;
    logic [6:0]  hdr;
    logic [6:0]  p;
    logic [31:0] v;
    bit          typed;   // expected answer given in the row
    answer_t     ans;
  } cmd_t;

  // Shadow of the node store
  logic [6:0]  links [NODES];
  logic [31:0] vals  [NODES];
  bit          written [NODES];

  answer_t answer_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      snd_idle = 10, rcv_idle = 0;
  bit      rcv_hold = 0;
  bit      done = 0;

  // Lists currently owned by the stimulus: header nodes
  int hdr_list[$];

  function automatic logic [6:0] walk_tail(logic [6:0] start);
    logic [6:0] cur;
    cur = start;
    for (int s = 0; s < NODES; s++) begin
      if (links[cur] == 0) break;
      cur = links[cur];
    end
    return cur;
  endfunction

  function automatic logic [6:0] lookup(logic [6:0] hdr, logic [31:0] x,
                                        output logic [6:0] prev);
    logic [6:0] last, cur;
    last = hdr;
    cur = links[hdr];
    for (int s = 0; s < NODES && cur != 0; s++) begin
      if (vals[cur] == x) begin
        prev = last;
        return cur;
      end
      last = cur;
      cur = links[cur];
    end
    prev = hdr;
    return 7'd0;
  endfunction

  function automatic answer_t apply_action(cmd_t c);
    answer_t r;
    logic [6:0] node, prev, t;
    r = '0;
    case (c.act)
      ACT_INSERT: begin
        node = links[0];
        if (node == 0) r.ostat = ST_NO_FREE;
        else begin
          links[0] = links[node];
          links[node] = links[c.p];
          links[c.p] = node;
          vals[node] = c.v;
          written[node] = 1;
          r.opos = node;
        end
      end
      ACT_DELETE: begin
        node = lookup(c.hdr, c.v, prev);
        if (node == 0) r.ostat = ST_NOT_FOUND;
        else begin
          links[prev] = links[node];
          t = walk_tail(0);
          links[t] = node;
          links[node] = 0;
          r.opos = node;
        end
      end
      ACT_FIND: begin
        node = lookup(c.hdr, c.v, prev);
        if (node == 0) r.ostat = ST_NOT_FOUND;
        r.opos = node;
      end
      ACT_MAKE_EMPTY: begin
        t = walk_tail(0);
        links[t] = links[c.hdr];
        links[c.hdr] = 0;
      end
      ACT_DELETE_LIST: begin
        t = walk_tail(c.hdr);
        links[t] = links[0];
        links[0] = c.hdr;
      end
      ACT_ADVANCE: begin
        r.opos = links[c.p];
        r.oflag = (links[c.p] == 0);
      end
      ACT_RETRIEVE: r.oval = vals[c.p];
      default: r.oflag = (links[c.hdr] == 0);
    endcase
    return r;
  endfunction

  // True when every node reachable from hdr holds a written value, so a
  // search there never reads an unwritten entry.
  function automatic bit list_clean(logic [6:0] hdr);
    logic [6:0] cur;
    cur = links[hdr];
    for (int s = 0; s < NODES && cur != 0; s++) begin
      if (!written[cur]) return 0;
      cur = links[cur];
    end
    return 1;
  endfunction

  // Drive one item and queue its expected answer on acceptance.
  task automatic send_item(cmd_t c);
    answer_t exp_ans;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= c.act;
    header <= c.hdr;
    pos <= c.p;
    value <= c.v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_ans = apply_action(c);
    answer_q.push_back(c.typed ? c.ans : exp_ans);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (rcv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Checker
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (out_pos !== e.opos) begin
          $error("out_pos expected %0d actual %0d", e.opos, out_pos); errors++;
        end
        if (out_value !== e.oval) begin
          $error("out_value expected %0h actual %0h", e.oval, out_value); errors++;
        end
        if (flag !== e.oflag) begin
          $error("flag expected %0b actual %0b", e.oflag, flag); errors++;
        end
        if (status !== e.ostat) begin
          $error("status expected %0d actual %0d", e.ostat, status); errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000 && !done) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic cmd_t mk(action_t a, int h, int p, logic [31:0] v);
    cmd_t c;
    c.act = a; c.hdr = 7'(h); c.p = 7'(p); c.v = v; c.typed = 0; c.ans = '0;
    return c;
  endfunction

  function automatic cmd_t mk_typed(action_t a, int h, int p, logic [31:0] v,
                                    answer_t ans);
    cmd_t c;
    c = mk(a, h, p, v);
    c.typed = 1;
    c.ans = ans;
    return c;
  endfunction

  // Random item, built so searches only cover written nodes.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int h, k, sel;
    logic [6:0] cur;
    int nodes_of[$];
    // an empty free list is sometimes refilled with a random node and the chain that follows it
    if (links[0] == 0 && $urandom_range(3) == 0) begin
      c = mk(ACT_DELETE_LIST, $urandom_range(127, 1), $urandom_range(127), $urandom);
      return c;
    end
    h = hdr_list.size() ? hdr_list[$urandom_range(hdr_list.size() - 1)] : 0;
    // collect nodes of h for well-formed operands
    cur = links[h];
    for (int s = 0; s < NODES && cur != 0; s++) begin
      nodes_of.push_back(int'(cur));
      cur = links[cur];
    end
    sel = $urandom_range(99);
    if (sel < 35) begin
      k = nodes_of.size() && $urandom_range(1) ? nodes_of[$urandom_range(nodes_of.size()-1)]
                                               : h;
      c = mk(ACT_INSERT, $urandom_range(127), k,
             $urandom_range(3) == 0 ? $urandom : $urandom_range(15));
    end else if (sel < 55 || sel < 70) begin
      c = mk(sel < 55 ? ACT_DELETE : ACT_FIND, h, $urandom_range(127),
             nodes_of.size() && $urandom_range(3) ?
               vals[nodes_of[$urandom_range(nodes_of.size()-1)]] : $urandom_range(15));
      if (!list_clean(7'(h))) c.act = ACT_IS_EMPTY;
    end else if (sel < 78) begin
      c = mk(ACT_ADVANCE, $urandom_range(127), $urandom_range(127), $urandom);
    end else if (sel < 86) begin
      k = $urandom_range(127);
      c = mk(ACT_RETRIEVE, $urandom_range(127), k, $urandom);
      if (!written[k]) c.p = nodes_of.size() ? 7'(nodes_of[0]) : 7'd0;
      if (!written[c.p]) c.act = ACT_IS_EMPTY;
    end else if (sel < 93) begin
      c = mk(ACT_IS_EMPTY, $urandom_range(127), $urandom_range(127), $urandom);
    end else if (sel < 97) begin
      c = mk(ACT_MAKE_EMPTY, h, $urandom_range(127), $urandom);
    end else begin
      // recycle list h onto the free list, or make it empty when h is node 0
      c = mk(ACT_DELETE_LIST, h, $urandom_range(127), $urandom);
      if (h == 0) c.act = ACT_MAKE_EMPTY;
    end
    return c;
  endfunction

  initial begin
    cmd_t dir_tbl[$];
    cmd_t c;
    logic [6:0] f;
    // shadow store after reset: chain 0 -> 1 -> ... -> NODES-1 -> 0
    foreach (links[i]) begin
      links[i] = (i + 1 < NODES) ? 7'(i + 1) : 7'd0;
      vals[i] = '0;
      written[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Node 1 is the free head after reset.
    dir_tbl.push_back(mk_typed(ACT_IS_EMPTY, 127, 0, 0, '{7'd0, 32'd0, 1'b1, ST_OK}));
    dir_tbl.push_back(mk_typed(ACT_ADVANCE, 0, 126, 0, '{7'd127, 32'd0, 1'b0, ST_OK}));
    dir_tbl.push_back(mk_typed(ACT_ADVANCE, 0, 127, 0, '{7'd0, 32'd0, 1'b1, ST_OK}));
    dir_tbl.push_back(mk_typed(ACT_IS_EMPTY, 0, 0, 0, '{7'd0, 32'd0, 1'b0, ST_OK}));
    // build header node 1 owning an empty list: insert after 127, whose link is 0
    dir_tbl.push_back(mk_typed(ACT_INSERT, 0, 127, 32'h8000_0000,
                               '{7'd1, 32'd0, 1'b0, ST_OK}));
    dir_tbl.push_back(mk_typed(ACT_RETRIEVE, 0, 1, 0,
                               '{7'd0, 32'h8000_0000, 1'b0, ST_OK}));
    dir_tbl.push_back(mk(ACT_INSERT, 0, 1, 32'h7FFF_FFFF));
    dir_tbl.push_back(mk(ACT_INSERT, 0, 1, 32'hFFFF_FFFF));
    dir_tbl.push_back(mk(ACT_INSERT, 0, 1, 32'h0));
    dir_tbl.push_back(mk(ACT_FIND, 1, 0, 32'h7FFF_FFFF));
    dir_tbl.push_back(mk(ACT_FIND, 1, 0, 32'h1234_5678));
    dir_tbl.push_back(mk(ACT_DELETE, 1, 0, 32'hFFFF_FFFF));
    dir_tbl.push_back(mk(ACT_DELETE, 1, 0, 32'h5555_AAAA));
    dir_tbl.push_back(mk(ACT_ADVANCE, 0, 1, 0));
    dir_tbl.push_back(mk(ACT_IS_EMPTY, 1, 0, 0));
    dir_tbl.push_back(mk(ACT_INSERT, 0, 1, 32'h0000_0055)); // insert after own header
    dir_tbl.push_back(mk(ACT_MAKE_EMPTY, 1, 0, 0));
    dir_tbl.push_back(mk(ACT_IS_EMPTY, 1, 0, 0));
    dir_tbl.push_back(mk(ACT_INSERT, 0, 2, 32'hAAAA_5555));  // insert after node 2, which make-empty moved off list 1
    dir_tbl.push_back(mk(ACT_DELETE_LIST, 1, 0, 0));
    foreach (dir_tbl[i]) send_item(dir_tbl[i]);
    drain_results();

    // Empty the free list at once, hit the no-free-node case, then give the
    // old free chain back to the free list by deleting the list at its old head
    snd_idle = 0;
    f = links[0];
    send_item(mk(ACT_MAKE_EMPTY, 0, 0, 0));
    send_item(mk_typed(ACT_INSERT, 0, 0, 32'h1, '{7'd0, 32'd0, 1'b0, ST_NO_FREE}));
    send_item(mk(ACT_DELETE_LIST, int'(f), 0, 0));
    drain_results();

    // Random phases on the chain headed by node 0
    hdr_list.push_back(0);
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 10 : (ph == 1) ? 69 : 0;
      rcv_idle = (ph == 0) ? 69 : (ph == 1) ? 10 : 0;
      for (int n = 0; n < 660; n++) begin
        c = rand_cmd();
        send_item(c);
        if (n == 300 && ph == 2) begin
          drain_results();       // sender pauses until all results are back
          fork
            begin
              rcv_hold = 1;
              repeat (400) @(posedge clk);
              rcv_hold = 0;
            end
          join_none
        end
      end
      drain_results();
    end
    repeat (600) @(posedge clk);
    done = 1;
    if (errors == 0 && answer_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
